FILE: design/efp_pkg.sv
// ----------------------------------------------------------------------------
// efp_pkg
// Shared widths, item kind codes and controller/datapath handshake structs
// for the Euler path walker.
// ----------------------------------------------------------------------------
package efp_pkg;

  localparam int KIND_W       = 2;
  localparam int VERT_W       = 3;
  localparam int RESULT_LIMIT = 64;
  localparam int COUNT_W      = $clog2(RESULT_LIMIT);

  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WALK  = 2'd2;

  typedef struct packed {
    logic add_edge;
    logic clear_all;
    logic load_start;
    logic reach_seed;
    logic reach_step;
    logic save_base;
    logic scan_load;
    logic try_next;
    logic restore;
    logic delete_pick;
    logic move;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic reach_done;
    logic same_base;
    logic cand_empty;
    logic slot_free;
    logic last;
  } status_t;

endpackage

FILE: design/efp_req_if.sv
// ----------------------------------------------------------------------------
// efp_req_if
// Request channel: add edge, clear graph or run a walk.
// ----------------------------------------------------------------------------
interface efp_req_if;
  logic                        valid;
  logic                        ready;
  logic [efp_pkg::KIND_W-1:0]  kind;
  logic [efp_pkg::VERT_W-1:0]  vertex_a;
  logic [efp_pkg::VERT_W-1:0]  vertex_b;

  modport source (output valid, kind, vertex_a, vertex_b, input ready);
  modport sink   (input valid, kind, vertex_a, vertex_b, output ready);
endinterface

FILE: design/efp_rsp_if.sv
// ----------------------------------------------------------------------------
// efp_rsp_if
// Result channel: one word per vertex of the walk.
// ----------------------------------------------------------------------------
interface efp_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [efp_pkg::VERT_W-1:0]  vertex;
  logic                        last;

  modport source (output valid, vertex, last, input ready);
  modport sink   (input valid, vertex, last, output ready);
endinterface

FILE: design/efp_datapath.sv
// ----------------------------------------------------------------------------
// efp_datapath
// Adjacency registers, frontier-expansion reachability unit, candidate scan
// registers, walk position and the result output register.
// ----------------------------------------------------------------------------
module efp_datapath #(
  parameter int NV = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  efp_pkg::cmd_t              cmd,
  output efp_pkg::status_t           status,
  input  logic [efp_pkg::VERT_W-1:0] vertex_a,
  input  logic [efp_pkg::VERT_W-1:0] vertex_b,
  efp_rsp_if.source                  rsp
);

  localparam int IW = (NV > 1) ? $clog2(NV) : 1;
  localparam int VW = efp_pkg::VERT_W;
  localparam int CW = efp_pkg::COUNT_W;

  logic [NV-1:0] rows [NV];
  logic [NV-1:0] visited;
  logic [NV-1:0] base;
  logic [NV-1:0] cand;
  logic [IW-1:0] pick;
  logic [VW-1:0] cur;
  logic [CW-1:0] count;

  logic [NV-1:0] reach_next;
  logic [NV-1:0] cur_row;
  logic [NV-1:0] cur_onehot;
  logic [IW-1:0] lo;
  logic [IW-1:0] edge_p;
  logic [IW-1:0] cur_idx;
  logic [IW-1:0] a_idx;
  logic [IW-1:0] b_idx;
  logic          cur_ok;
  logic          a_ok;
  logic          b_ok;
  logic          last_w;
  logic          sym_ok;
  logic          any_edge;

  assign cur_ok  = (32'(cur) < NV);
  assign a_ok    = (32'(vertex_a) < NV);
  assign b_ok    = (32'(vertex_b) < NV);
  assign cur_idx = IW'(cur);
  assign a_idx   = IW'(vertex_a);
  assign b_idx   = IW'(vertex_b);

  assign cur_row    = cur_ok ? rows[cur_idx] : '0;
  assign cur_onehot = NV'(1) << cur_idx;
  assign edge_p     = cmd.try_next ? lo : pick;

  // one breadth step: add every neighbour of the marked set
  always_comb begin
    reach_next = visited;
    for (int u = 0; u < NV; u++) begin
      if (visited[u]) begin
        reach_next = reach_next | rows[u];
      end
    end
  end

  // lowest remaining candidate
  always_comb begin
    lo = '0;
    for (int i = NV - 1; i >= 0; i--) begin
      if (cand[i]) begin
        lo = IW'(i);
      end
    end
  end

  assign last_w = !cur_ok || (cur_row == '0) || (count == CW'(efp_pkg::RESULT_LIMIT - 1));

  assign status.reach_done = (reach_next == visited);
  assign status.same_base  = (visited == base);
  assign status.cand_empty = (cand == '0);
  assign status.slot_free  = !rsp.valid || rsp.ready;
  assign status.last       = last_w;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      for (int i = 0; i < NV; i++) begin
        rows[i] <= '0;
      end
    end else begin
      if (cmd.add_edge && a_ok && b_ok) begin
        rows[a_idx][b_idx] <= 1'b1;
        rows[b_idx][a_idx] <= 1'b1;
      end
      if (cmd.try_next || cmd.delete_pick) begin
        rows[cur_idx][edge_p] <= 1'b0;
        rows[edge_p][cur_idx] <= 1'b0;
      end
      if (cmd.restore) begin
        rows[cur_idx][edge_p] <= 1'b1;
        rows[edge_p][cur_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.reach_seed || cmd.try_next) begin
      visited <= cur_onehot;
    end else if (cmd.reach_step) begin
      visited <= reach_next;
    end
    if (cmd.save_base) begin
      base <= visited;
    end
    if (cmd.scan_load) begin
      cand <= cur_row;
    end else if (cmd.try_next) begin
      cand <= cand & ~(NV'(1) << lo);
    end
    if (cmd.try_next) begin
      pick <= lo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur       <= '0;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (cmd.load_start) begin
        cur   <= vertex_a;
        count <= '0;
      end else if (cmd.move) begin
        cur <= VW'(pick);
      end
      if (cmd.emit) begin
        count     <= count + CW'(1);
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp.vertex <= cur;
      rsp.last   <= last_w;
    end
  end

  always_comb begin
    sym_ok   = 1'b1;
    any_edge = 1'b0;
    for (int i = 0; i < NV; i++) begin
      any_edge = any_edge | (|rows[i]);
      for (int j = 0; j < NV; j++) begin
        if (rows[i][j] != rows[j][i]) begin
          sym_ok = 1'b0;
        end
      end
    end
  end

  a_symmetric: assert property (@(posedge clk) disable iff (rst) sym_ok)
    else $error("adjacency matrix lost symmetry");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_all |=> !any_edge)
    else $error("graph not empty after clear");

  a_reach_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.reach_step |=> ((visited & $past(visited)) == $past(visited)))
    else $error("reachable set shrank during search");

endmodule

FILE: design/efp_ctrl.sv
// ----------------------------------------------------------------------------
// efp_ctrl
// Walk sequencer: takes requests, runs the base search, tries candidate
// edges in ascending order and hands each vertex to the output register.
// ----------------------------------------------------------------------------
module efp_ctrl (
  input  logic             clk,
  input  logic             rst,
  efp_req_if.sink          req,
  input  efp_pkg::status_t status,
  output efp_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    IDLE,
    EMIT,
    BASE_RUN,
    SCAN,
    TEST_RUN
  } state_t;

  state_t state;
  state_t state_next;

  assign req.ready = (state == IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (req.valid) begin
          unique case (req.kind)
            efp_pkg::KIND_ADD:   cmd.add_edge = 1'b1;
            efp_pkg::KIND_CLEAR: cmd.clear_all = 1'b1;
            efp_pkg::KIND_WALK: begin
              cmd.load_start = 1'b1;
              state_next     = EMIT;
            end
            default: ;
          endcase
        end
      end
      EMIT: begin
        if (status.slot_free) begin
          cmd.emit       = 1'b1;
          cmd.reach_seed = 1'b1;
          cmd.scan_load  = 1'b1;
          state_next     = status.last ? IDLE : BASE_RUN;
        end
      end
      BASE_RUN: begin
        if (status.reach_done) begin
          cmd.save_base = 1'b1;
          state_next    = SCAN;
        end else begin
          cmd.reach_step = 1'b1;
        end
      end
      SCAN: begin
        // all candidates were bridges: take the highest one tried
        if (status.cand_empty) begin
          cmd.delete_pick = 1'b1;
          cmd.move        = 1'b1;
          state_next      = EMIT;
        end else begin
          cmd.try_next = 1'b1;
          state_next   = TEST_RUN;
        end
      end
      TEST_RUN: begin
        if (status.reach_done) begin
          if (status.same_base) begin
            cmd.move   = 1'b1;
            state_next = EMIT;
          end else begin
            cmd.restore = 1'b1;
            state_next  = SCAN;
          end
        end else begin
          cmd.reach_step = 1'b1;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_last_ends_walk: assert property (@(posedge clk) disable iff (rst)
    (state == EMIT && status.slot_free && status.last) |=> state == IDLE)
    else $error("walk continued after final vertex");

  a_bridge_restored: assert property (@(posedge clk) disable iff (rst)
    cmd.restore |=> state == SCAN && !$past(status.same_base))
    else $error("edge restored without a bridge result");

  a_start_loads: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.kind == efp_pkg::KIND_WALK) |=> state == EMIT)
    else $error("walk request did not start emission");

endmodule

FILE: design/euler_path_fleury_walker.sv
// ----------------------------------------------------------------------------
// euler_path_fleury_walker
// Euler walk over a small undirected graph by Fleury's rule.
// ----------------------------------------------------------------------------
// An add-edge or clear request is carried out in the idle state. A walk
// request emits the start vertex and then one word per traversed edge, at
// most 64 words, the final one marked last. Each step runs a
// frontier-expansion reachability search over the adjacency registers from
// the current vertex. It then takes each candidate edge in ascending order,
// lifts it and runs another search. When every edge there is a bridge, it
// drops the last edge tried. Finally it hands the vertex to the output
// register. A new request is taken only once the walk before it has handed
// over its final word.
module euler_path_fleury_walker #(
  parameter int MAX_VERTICES = 8
) (
  input  logic      clk,
  input  logic      rst,
  efp_req_if.sink   req,
  efp_rsp_if.source rsp
);

  efp_pkg::cmd_t    cmd;
  efp_pkg::status_t status;

  efp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .status (status),
    .cmd    (cmd)
  );

  efp_datapath #(
    .NV (MAX_VERTICES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .vertex_a (req.vertex_a),
    .vertex_b (req.vertex_b),
    .rsp      (rsp)
  );

endmodule
